/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, ck, rn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
		else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/elcp_pkg.sv */
// Shared types, widths and the output saturation function of the edge projection.
// No dependencies.
package elcp_pkg;

	localparam int S_W        = 66;
	localparam int ROOT_W     = 35;
	localparam int TRIAL_W    = 72;
	localparam int NUM_W      = 96;
	localparam int FRAC_SHIFT = 17;
	localparam int DEN_W      = ROOT_W + FRAC_SHIFT;
	localparam int Q_W        = 33;
	localparam int PIPE_DEPTH = 4 + ROOT_W + 1 + Q_W + 1;

	typedef logic [NUM_W-1:0] num_t;

	typedef struct packed {
		logic        ign;
		logic        degen;
		logic [15:0] va;
		logic [15:0] vb;
		logic [2:0]  pos;
	} meta_t;

	typedef struct packed {
		meta_t      meta;
		num_t [2:0] num;
	} sq_side_t;

	typedef struct packed {
		logic           sat;
		logic [Q_W-1:0] q;
		num_t           rem;
	} div_axis_t;

	typedef div_axis_t [2:0] div_axes_t;

	function automatic logic [31:0] axis_result(input logic pos, input div_axis_t a);
		logic [Q_W-1:0] mag;
		logic [Q_W-1:0] neg;
		mag = a.sat ? {1'b1, 32'h0} : a.q;
		if (pos) begin
			if (mag > {1'b0, 32'h8000_0000}) mag = {1'b0, 32'h8000_0000};
			neg = ~mag + {{(Q_W-1){1'b0}}, 1'b1};
			return neg[31:0];
		end
		if (mag > {1'b0, 32'h7FFF_FFFF}) mag = {1'b0, 32'h7FFF_FFFF};
		return mag[31:0];
	endfunction

endpackage

/* rtl/core/edge_length_constraint_projection.sv */
// Top level of the edge length projection: input stages, square root and divider chains.
// Depends on elcp_pkg, elcp_sqrt_cell and elcp_div_cell.
// A request is taken in every cycle and busy never rises. Each request gives one result,
// marked by done, after the input stages, the 35 square root cells, the 33 divider cells
// and the registers around them. Results cannot be held off and leave in request order.
module edge_length_constraint_projection #(
	parameter int unsigned MAX_VERTICES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic        [15:0] vertex_a,
	input  logic        [15:0] vertex_b,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by_coord,
	input  logic signed [31:0] bz,
	input  logic        [31:0] weight,
	input  logic        [31:0] rest_length,
	output logic               done,
	output logic        [15:0] target_a,
	output logic        [15:0] target_b,
	output logic signed [31:0] contrib_x,
	output logic signed [31:0] contrib_y,
	output logic signed [31:0] contrib_z,
	output logic               degenerate
);
	localparam int RW = elcp_pkg::ROOT_W;
	localparam int QW = elcp_pkg::Q_W;

	logic [31:0] a_in [3];
	logic [31:0] b_in [3];
	logic        ign;

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [15:0] va_s1, va_s2, va_s3, va_s4;
	logic [15:0] vb_s1, vb_s2, vb_s3, vb_s4;
	logic        ign_s1, ign_s2, ign_s3, ign_s4;
	logic [2:0]  pos_s1, pos_s2, pos_s3, pos_s4;
	logic [31:0] mag_s1 [3];
	logic [31:0] mag_s2 [3];
	logic [31:0] w_s1, d_s1;
	logic [63:0] sq_s2 [3];
	logic [63:0] wd_s2;
	logic [elcp_pkg::S_W-1:0] s_s3, s_s4;
	logic [63:0] plo_s3 [3];
	logic [63:0] phi_s3 [3];
	elcp_pkg::num_t num_s4 [3];
	logic        degen_s4;

	logic                     sq_v    [0:RW];
	logic [elcp_pkg::S_W-1:0] sq_rem  [0:RW];
	logic [RW-1:0]            sq_root [0:RW];
	elcp_pkg::sq_side_t       sq_side [0:RW];

	elcp_pkg::meta_t            meta_s5;
	logic [elcp_pkg::DEN_W-1:0] den_s5;
	elcp_pkg::div_axes_t        axes_s5;
	elcp_pkg::sq_side_t         side_end;
	logic [elcp_pkg::DEN_W-1:0] den_end;

	logic                       dv_v    [0:QW];
	elcp_pkg::meta_t            dv_meta [0:QW];
	logic [elcp_pkg::DEN_W-1:0] dv_den  [0:QW];
	elcp_pkg::div_axes_t        dv_axes [0:QW];

	elcp_pkg::meta_t            fm;
	logic                       zero_out;

	assign busy = 1'b0;

	assign a_in[0] = ax;
	assign a_in[1] = ay;
	assign a_in[2] = az;
	assign b_in[0] = bx;
	assign b_in[1] = by_coord;
	assign b_in[2] = bz;
	assign ign = (32'(vertex_a) >= 32'(MAX_VERTICES)) || (32'(vertex_b) >= 32'(MAX_VERTICES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= sq_v[RW];
			done     <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		logic [32:0] diff;
		va_s1  <= vertex_a;
		vb_s1  <= vertex_b;
		ign_s1 <= ign;
		w_s1   <= weight;
		d_s1   <= rest_length;
		for (int i = 0; i < 3; i++) begin
			diff = {b_in[i][31], b_in[i]} - {a_in[i][31], a_in[i]};
			mag_s1[i] <= diff[32] ? 32'(~diff + 33'd1) : diff[31:0];
			pos_s1[i] <= !diff[32] && (diff != 33'd0);
		end
	end

	always_ff @(posedge clk) begin
		va_s2  <= va_s1;
		vb_s2  <= vb_s1;
		ign_s2 <= ign_s1;
		pos_s2 <= pos_s1;
		wd_s2  <= 64'(w_s1) * 64'(d_s1);
		for (int i = 0; i < 3; i++) begin
			mag_s2[i] <= mag_s1[i];
			sq_s2[i]  <= 64'(mag_s1[i]) * 64'(mag_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		va_s3  <= va_s2;
		vb_s3  <= vb_s2;
		ign_s3 <= ign_s2;
		pos_s3 <= pos_s2;
		s_s3   <= elcp_pkg::S_W'(sq_s2[0]) + elcp_pkg::S_W'(sq_s2[1])
			+ elcp_pkg::S_W'(sq_s2[2]);
		for (int i = 0; i < 3; i++) begin
			plo_s3[i] <= 64'(wd_s2[31:0]) * 64'(mag_s2[i]);
			phi_s3[i] <= 64'(wd_s2[63:32]) * 64'(mag_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		va_s4    <= va_s3;
		vb_s4    <= vb_s3;
		ign_s4   <= ign_s3;
		pos_s4   <= pos_s3;
		s_s4     <= s_s3;
		degen_s4 <= s_s3 == '0;
		for (int i = 0; i < 3; i++) begin
			num_s4[i] <= elcp_pkg::NUM_W'(plo_s3[i]) + (elcp_pkg::NUM_W'(phi_s3[i]) << 32);
		end
	end

	assign sq_v[0]    = valid_s4;
	assign sq_rem[0]  = s_s4;
	assign sq_root[0] = '0;
	assign sq_side[0] = '{meta: '{ign: ign_s4, degen: degen_s4, va: va_s4, vb: vb_s4,
		pos: pos_s4}, num: {num_s4[2], num_s4[1], num_s4[0]}};

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		elcp_sqrt_cell #(.BIT(RW - 1 - k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (sq_v[k]),
			.in_rem   (sq_rem[k]),
			.in_root  (sq_root[k]),
			.in_side  (sq_side[k]),
			.out_valid(sq_v[k+1]),
			.out_rem  (sq_rem[k+1]),
			.out_root (sq_root[k+1]),
			.out_side (sq_side[k+1])
		);
	end

	assign side_end = sq_side[RW];
	assign den_end  = {sq_root[RW], {elcp_pkg::FRAC_SHIFT{1'b0}}};

	always_ff @(posedge clk) begin
		meta_s5 <= side_end.meta;
		den_s5  <= den_end;
		for (int i = 0; i < 3; i++) begin
			axes_s5[i].sat <= side_end.num[i] >= (elcp_pkg::NUM_W'(den_end) << QW);
			axes_s5[i].q   <= '0;
			axes_s5[i].rem <= side_end.num[i];
		end
	end

	assign dv_v[0]    = valid_s5;
	assign dv_meta[0] = meta_s5;
	assign dv_den[0]  = den_s5;
	assign dv_axes[0] = axes_s5;

	for (genvar k = 0; k < QW; k++) begin : g_div
		elcp_div_cell #(.BIT(QW - 1 - k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv_v[k]),
			.in_meta  (dv_meta[k]),
			.in_den   (dv_den[k]),
			.in_axes  (dv_axes[k]),
			.out_valid(dv_v[k+1]),
			.out_meta (dv_meta[k+1]),
			.out_den  (dv_den[k+1]),
			.out_axes (dv_axes[k+1])
		);
	end

	assign fm       = dv_meta[QW];
	assign zero_out = fm.ign || fm.degen;

	always_ff @(posedge clk) begin
		target_a   <= fm.va;
		target_b   <= fm.vb;
		degenerate <= fm.degen && !fm.ign;
		contrib_x  <= zero_out ? '0 : elcp_pkg::axis_result(fm.pos[0], dv_axes[QW][0]);
		contrib_y  <= zero_out ? '0 : elcp_pkg::axis_result(fm.pos[1], dv_axes[QW][1]);
		contrib_z  <= zero_out ? '0 : elcp_pkg::axis_result(fm.pos[2], dv_axes[QW][2]);
	end
endmodule

/* rtl/core/elcp_sqrt_cell.sv */
// One bit of the square root chain: tries one root bit and passes the data on.
// Depends on elcp_pkg.
module elcp_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [elcp_pkg::S_W-1:0]    in_rem,
	input  logic [elcp_pkg::ROOT_W-1:0] in_root,
	input  elcp_pkg::sq_side_t          in_side,
	output logic                        out_valid,
	output logic [elcp_pkg::S_W-1:0]    out_rem,
	output logic [elcp_pkg::ROOT_W-1:0] out_root,
	output elcp_pkg::sq_side_t          out_side
);
	logic [elcp_pkg::TRIAL_W-1:0] trial;
	logic                         take;

	assign trial = (elcp_pkg::TRIAL_W'(in_root) << (BIT + 1))
		| (elcp_pkg::TRIAL_W'(1) << (2 * BIT));
	assign take = elcp_pkg::TRIAL_W'(in_rem) >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		out_side <= in_side;
		if (take) begin
			out_rem  <= in_rem - trial[elcp_pkg::S_W-1:0];
			out_root <= in_root | (elcp_pkg::ROOT_W'(1) << BIT);
		end else begin
			out_rem  <= in_rem;
			out_root <= in_root;
		end
	end
endmodule

/* rtl/core/elcp_div_cell.sv */
// One quotient bit of the three-axis restoring divider chain.
// Depends on elcp_pkg.
module elcp_div_cell #(
	parameter int BIT = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  elcp_pkg::meta_t            in_meta,
	input  logic [elcp_pkg::DEN_W-1:0] in_den,
	input  elcp_pkg::div_axes_t        in_axes,
	output logic                       out_valid,
	output elcp_pkg::meta_t            out_meta,
	output logic [elcp_pkg::DEN_W-1:0] out_den,
	output elcp_pkg::div_axes_t        out_axes
);
	elcp_pkg::num_t      trial;
	elcp_pkg::div_axes_t nxt;

	assign trial = elcp_pkg::NUM_W'(in_den) << BIT;

	always_comb begin
		nxt = in_axes;
		for (int i = 0; i < 3; i++) begin
			if (!in_axes[i].sat && in_axes[i].rem >= trial) begin
				nxt[i].rem    = in_axes[i].rem - trial;
				nxt[i].q[BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		out_meta <= in_meta;
		out_den  <= in_den;
		out_axes <= nxt;
	end
endmodule

/* rtl/core/elcp_checker.sv */
// Port-level checks of the edge length projection, bound to its top level.
// Depends on elcp_pkg, assert_macros.svh and edge_length_constraint_projection.
`include "assert_macros.svh"

module elcp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic signed [31:0] ax,
	input logic signed [31:0] bx,
	input logic               done,
	input logic signed [31:0] contrib_x,
	input logic signed [31:0] contrib_y,
	input logic signed [31:0] contrib_z,
	input logic               degenerate
);
	localparam int LAT = elcp_pkg::PIPE_DEPTH;

	`CHK_ALWAYS(a_never_busy, clk, arst_n, !busy)
	`CHK_IMPLY(a_done_has_request, clk, arst_n, done, $past(start, LAT))
	`CHK_IMPLY(a_degen_zero, clk, arst_n, done && degenerate,
		contrib_x == 0 && contrib_y == 0 && contrib_z == 0)
	`CHK_IMPLY(a_flat_x_zero, clk, arst_n,
		done && $past(start, LAT) && $past(ax, LAT) == $past(bx, LAT), contrib_x == 0)
endmodule

bind edge_length_constraint_projection elcp_checker u_elcp_checker (.*);

/* test/edge_projection_checker.sv */
// Checker for the edge length projection: predicts each contribution from the request
// and compares it with the result stream in order. Depends on nothing but its ports.
module edge_projection_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic        [15:0] vertex_a,
	input  logic        [15:0] vertex_b,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by_coord,
	input  logic signed [31:0] bz,
	input  logic        [31:0] weight,
	input  logic        [31:0] rest_length,
	input  logic               done,
	input  logic        [15:0] target_a,
	input  logic        [15:0] target_b,
	input  logic signed [31:0] contrib_x,
	input  logic signed [31:0] contrib_y,
	input  logic signed [31:0] contrib_z,
	input  logic               degenerate,
	output int                 fails,
	output int                 pending
);

	localparam int unsigned VERTEX_LIMIT = 65536;

	typedef struct packed {
		logic [15:0] ta;
		logic [15:0] tb;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
		logic        degen;
	} contrib_t;

	contrib_t expected_contribs[$];

	function automatic logic [32:0] magnitude(input logic signed [32:0] d);
		return d < 0 ? -d : d;
	endfunction

	function automatic logic [31:0] axis_contrib(input logic signed [32:0] d,
			input logic [63:0] wd, input logic [51:0] den);
		logic [95:0] num;
		logic [95:0] q;
		num = {32'b0, wd} * {63'b0, magnitude(d)};
		q = num / {44'b0, den};
		if (d > 0) begin
			if (q > 96'h8000_0000) q = 96'h8000_0000;
			return -q[31:0];
		end
		if (q > 96'h7FFF_FFFF) q = 96'h7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic contrib_t project_edge(input logic [15:0] va, input logic [15:0] vb,
			input logic signed [31:0] pax, input logic signed [31:0] pay,
			input logic signed [31:0] paz, input logic signed [31:0] pbx,
			input logic signed [31:0] pby, input logic signed [31:0] pbz,
			input logic [31:0] w, input logic [31:0] rl);
		contrib_t c;
		logic signed [32:0] dx, dy, dz;
		logic [65:0] s;
		logic [71:0] sq;
		logic [34:0] root, trial;
		logic [51:0] den;
		logic [63:0] wd;
		c = '0;
		c.ta = va;
		c.tb = vb;
		if (va >= VERTEX_LIMIT || vb >= VERTEX_LIMIT) return c;
		dx = $signed({pbx[31], pbx}) - $signed({pax[31], pax});
		dy = $signed({pby[31], pby}) - $signed({pay[31], pay});
		dz = $signed({pbz[31], pbz}) - $signed({paz[31], paz});
		s = {33'b0, magnitude(dx)} * {33'b0, magnitude(dx)}
			+ {33'b0, magnitude(dy)} * {33'b0, magnitude(dy)}
			+ {33'b0, magnitude(dz)} * {33'b0, magnitude(dz)};
		if (s == 0) begin
			c.degen = 1'b1;
			return c;
		end
		root = '0;
		for (int b = 34; b >= 0; b--) begin
			trial = root | (35'd1 << b);
			sq = {37'b0, trial} * {37'b0, trial};
			if (sq <= {6'b0, s}) root = trial;
		end
		den = {root, 17'b0};
		wd = {32'b0, w} * {32'b0, rl};
		c.cx = axis_contrib(dx, wd, den);
		c.cy = axis_contrib(dy, wd, den);
		c.cz = axis_contrib(dz, wd, den);
		return c;
	endfunction

	assign pending = expected_contribs.size();

	task automatic report(input string name, input logic [31:0] e, input logic [31:0] a);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
		fails++;
	endtask

	initial fails = 0;

	always @(posedge clk) begin
		contrib_t e;
		if (arst_n) begin
			if (done) begin
				if (expected_contribs.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h %h", $time,
						target_a, target_b);
					fails++;
				end else begin
					e = expected_contribs.pop_front();
					if (target_a !== e.ta) report("target_a", e.ta, target_a);
					if (target_b !== e.tb) report("target_b", e.tb, target_b);
					if (contrib_x !== e.cx) report("contrib_x", e.cx, contrib_x);
					if (contrib_y !== e.cy) report("contrib_y", e.cy, contrib_y);
					if (contrib_z !== e.cz) report("contrib_z", e.cz, contrib_z);
					if (degenerate !== e.degen) report("degenerate", e.degen, degenerate);
				end
			end
			if (start && !busy)
				expected_contribs.push_back(project_edge(vertex_a, vertex_b, ax, ay, az,
					bx, by_coord, bz, weight, rest_length));
		end
	end

endmodule

/* test/tb_edge_length_constraint_projection.sv */
// Testbench top for the edge length projection: drives directed edge requests and random
// ones with random gaps. Depends on the block and edge_projection_checker.
module tb_edge_length_constraint_projection;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic        [15:0] vertex_a;
	logic        [15:0] vertex_b;
	logic signed [31:0] ax, ay, az, bx, by_coord, bz;
	logic        [31:0] weight;
	logic        [31:0] rest_length;
	logic               done;
	logic        [15:0] target_a;
	logic        [15:0] target_b;
	logic signed [31:0] contrib_x, contrib_y, contrib_z;
	logic               degenerate;
	int                 fails;
	int                 pending;

	edge_length_constraint_projection i_dut (.*);

	edge_projection_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 90);
	endfunction

	function automatic logic [31:0] pick_coord(input int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 2 * 65536 * 16)) - 65536 * 16;
			2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return $signed($urandom_range(0, 64)) - 32;
		endcase
	endfunction

	function automatic logic [31:0] pick_scalar();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom_range(0, 8 * 65536);
		endcase
	endfunction

	task automatic send_edge(input logic [15:0] va, input logic [15:0] vb,
			input logic [31:0] pax, input logic [31:0] pay, input logic [31:0] paz,
			input logic [31:0] pbx, input logic [31:0] pby, input logic [31:0] pbz,
			input logic [31:0] w, input logic [31:0] rl, input int gap);
		start <= 1'b1;
		vertex_a <= va;
		vertex_b <= vb;
		ax <= pax;
		ay <= pay;
		az <= paz;
		bx <= pbx;
		by_coord <= pby;
		bz <= pbz;
		weight <= w;
		rest_length <= rl;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(input int gap);
		int m;
		logic [31:0] pax, pay, paz;
		m = $urandom_range(0, 9);
		m = m < 2 ? 0 : (m < 7 ? 1 : (m < 8 ? 2 : 3));
		pax = pick_coord(m);
		pay = pick_coord(m);
		paz = pick_coord(m);
		if ($urandom_range(0, 29) == 0)
			send_edge(16'($urandom), 16'($urandom), pax, pay, paz, pax, pay, paz,
				pick_scalar(), pick_scalar(), gap);
		else
			send_edge(16'($urandom), 16'($urandom), pax, pay, paz, pick_coord(m),
				pick_coord(m), pick_coord(m), pick_scalar(), pick_scalar(), gap);
	endtask

	initial begin
		#(8 * 400000);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		vertex_a = '0;
		vertex_b = '0;
		ax = '0;
		ay = '0;
		az = '0;
		bx = '0;
		by_coord = '0;
		bz = '0;
		weight = '0;
		rest_length = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_edge(16'd0, 16'hFFFF, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0,
			32'h10000, 32'h10000, 0);
		send_edge(16'd5, 16'd5, 32'h1234, 32'h5678, 32'h9ABC, 32'h1234, 32'h5678,
			32'h9ABC, 32'h10000, 32'h10000, 0);
		send_edge(16'hFFFF, 16'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		send_edge(16'd1, 16'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_edge(16'd3, 16'd4, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_edge(16'd3, 16'd4, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 2);
		send_edge(16'd7, 16'd8, 32'h10000, 32'h20000, 32'h30000, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h10000, 0);
		send_edge(16'd7, 16'd8, 32'h10000, 32'h20000, 32'h30000, 32'h0, 32'h0, 32'h0,
			32'h10000, 32'h0, 0);
		send_edge(16'd9, 16'd10, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0, 0);
		send_edge(16'hAAAA, 16'h5555, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0003_0000,
			32'hFFFD_0000, 32'h0004_0000, 32'h0002_8000, 32'h0001_8000, 3);
		send_edge(16'h5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 32'hAAAA_AAAA, 32'h5555_5555, 0);

		for (int n = 0; n < 1140; n++) begin
			if (n == 500) begin
				start <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			send_random((n % 200) < 30 ? 0 : pick_gap());
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
